// File: hw/rtl/ubc_pkg.sv
`default_nettype none

package ubc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBurst = 4;
  localparam int unsigned HoldMax  = 3;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] AsciiMax  = 8'h7F;
  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Lo   = 8'hE0;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] Lead4Lo   = 8'hF0;
  localparam logic [7:0] Lead4Hi   = 8'hF4;
  localparam logic [7:0] LeadE0    = 8'hE0;
  localparam logic [7:0] LeadED    = 8'hED;
  localparam logic [7:0] LeadF0    = 8'hF0;
  localparam logic [7:0] LeadF4    = 8'hF4;
  localparam logic [7:0] E0SecMin  = 8'hA0;
  localparam logic [7:0] EDSecMax  = 8'h9F;
  localparam logic [7:0] F0SecMin  = 8'h90;
  localparam logic [7:0] F4SecMax  = 8'h8F;

  // cmd codes carried on tuser
  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // one burst of released bytes, oldest byte in the lowest lane
  typedef struct packed {
    logic [MaxBurst*ByteW-1:0] bytes;
    logic [1:0]                last_idx;  // burst length minus one
  } chunk_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContTag;
  endfunction

  // sequence length started by a lead byte, 0 for a byte that is no lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b <= AsciiMax) len = 3'd1;
    else if (b >= Lead2Lo && b <= Lead2Hi) len = 3'd2;
    else if (b >= Lead3Lo && b <= Lead3Hi) len = 3'd3;
    else if (b >= Lead4Lo && b <= Lead4Hi) len = 3'd4;
    return len;
  endfunction

  // w holds the lead in bits 7:0 and the following bytes above it
  function automatic logic seq_ok(input logic [31:0] w, input logic [2:0] len);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       ok;
    b0 = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    b3 = w[31:24];
    case (len)
      3'd1: ok = b0 <= AsciiMax;
      3'd2: ok = is_cont(b1);
      3'd3: ok = is_cont(b1) && is_cont(b2) &&
                 (b0 != LeadE0 || b1 >= E0SecMin) &&
                 (b0 != LeadED || b1 <= EDSecMax);
      3'd4: ok = is_cont(b1) && is_cont(b2) && is_cont(b3) &&
                 (b0 != LeadF0 || b1 >= F0SecMin) &&
                 (b0 != LeadF4 || b1 <= F4SecMax);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ubc_front.sv
`default_nettype none

module ubc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_cmd_i,
  input  wire logic [7:0]      in_byte_i,
  output logic                 in_ready_o,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output ubc_pkg::chunk_t      q_data_o
);
  import ubc_pkg::*;

  logic [HoldMax*ByteW-1:0]  pend_q, pend_d;
  logic [1:0]                cnt_q, cnt_d;

  logic [MaxBurst*ByteW-1:0] buf_w;
  logic [7*ByteW-1:0]        buf_ext;
  logic [2:0]                n;
  logic [2:0]                len_p [MaxBurst];
  logic                      ok_p  [MaxBurst];
  logic [2:0]                idx;
  logic [2:0]                l;
  logic                      stop;
  logic [MaxBurst*ByteW-1:0] rest_w;
  logic [2:0]                emit_n;
  logic                      accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // append the new byte behind the held ones; lanes above the count are zero
  always_comb begin
    buf_w = {{ByteW{1'b0}}, pend_q};
    buf_w[cnt_q*ByteW +: ByteW] = in_byte_i;
  end
  assign n       = {1'b0, cnt_q} + 3'd1;
  assign buf_ext = {{(3*ByteW){1'b0}}, buf_w};

  // classify every start position in parallel
  for (genvar p = 0; p < MaxBurst; p++) begin : g_pos
    assign len_p[p] = lead_len(buf_w[p*ByteW +: ByteW]);
    assign ok_p[p]  = seq_ok(buf_ext[p*ByteW +: 4*ByteW], len_p[p]);
  end

  // scan: each step moves at least one byte or stops, four steps cover it
  always_comb begin
    idx  = 3'd0;
    stop = 1'b0;
    l    = 3'd0;
    for (int it = 0; it < MaxBurst; it++) begin
      if (!stop && idx < n) begin
        l = len_p[idx[1:0]];
        if (l == 3'd0) begin
          idx = idx + 3'd1;
        end else if (({1'b0, idx} + {1'b0, l}) > {1'b0, n}) begin
          stop = 1'b1;
        end else if (!ok_p[idx[1:0]]) begin
          idx = idx + 3'd1;
        end else begin
          idx = idx + l;
        end
      end
    end
  end

  assign rest_w = buf_w >> (idx * ByteW);

  always_comb begin
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    q_data_o = '0;
    emit_n   = 3'd0;
    if (in_cmd_i == CMD_FLUSH) begin
      q_data_o.bytes = {{ByteW{1'b0}}, pend_q};
      emit_n         = {1'b0, cnt_q};
      pend_d         = '0;
      cnt_d          = 2'd0;
    end else begin
      q_data_o.bytes = buf_w;
      emit_n         = idx;
      pend_d         = rest_w[HoldMax*ByteW-1:0];
      cnt_d          = 2'(n - idx);
    end
    q_data_o.last_idx = 2'(emit_n - 3'd1);
  end

  assign q_push_o = accept && (emit_n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= 2'd0;
    end else if (accept) begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ubc_fifo.sv
`default_nettype none

module ubc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ubc_pkg::chunk_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output ubc_pkg::chunk_t      data_o,
  output logic                 empty_o
);
  import ubc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  chunk_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ubc_back.sv
`default_nettype none

module ubc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire ubc_pkg::chunk_t q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  input  wire logic            out_ready_i
);
  import ubc_pkg::*;

  logic [1:0] idx_q;
  logic       fire;

  assign out_valid_o = !q_empty_i;
  assign out_byte_o  = q_data_i.bytes[idx_q*ByteW +: ByteW];
  assign out_last_o  = idx_q == q_data_i.last_idx;
  assign fire        = out_valid_o && out_ready_i;
  assign q_pop_o     = fire && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= out_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/utf8_boundary_chunker.sv
// Path: each released burst is written into the chunk queue and offered from its head.
// Throughput: one input item per cycle while the chunk queue has room; the output
//   side drains one byte per cycle while m_axis_tready_i is high.
// Reset: rst_ni async active low clears held bytes, queue pointers and the burst index.
`default_nettype none

module utf8_boundary_chunker #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input item stream
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tuser_i,   // [0] cmd (0 data, 1 flush)
  // released byte stream
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o    // chunk_end
);
  import ubc_pkg::*;

  chunk_t q_in, q_out;
  logic   q_push, q_pop, q_full, q_empty;

  // Front: holds up to three bytes of an unfinished character, scans the
  // held bytes plus the new one and queues the completed burst, or on a flush the held bytes.
  ubc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_ready_o (s_axis_tready_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  // Chunk queue: decouples the scan from a stalled output.
  ubc_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // Back: walks each burst one byte per item, tlast on its final byte.
  ubc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  import ubc_pkg::*;

  // one released byte as the block should offer it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rel_byte_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  // input stream, driven from the sender task
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = CMD_DATA;
  logic       s_tready;

  // released stream; ready toggled by the stall process below
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  // idle rates in percent, changed between phases
  int send_idle_pct = 18;
  int recv_idle_pct = 47;

  // predictor state: bytes held back at the tail of the stream
  logic [2:0][7:0] held_bytes = '0;
  int              held_cnt = 0;

  rel_byte_t rel_bytes_q[$];
  rel_byte_t rel_head;

  int errors = 0;
  int items_sent = 0;
  int flushes_sent = 0;
  int bytes_checked = 0;
  int drain;

  utf8_boundary_chunker uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] data_byte
    .s_axis_tuser_i  (s_tuser),   // [0] cmd
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] out_byte
    .m_axis_tlast_o  (m_tlast)    // chunk_end
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // bytes a lead starts; 0 means the byte cannot start a character
  function automatic int char_len(input logic [7:0] b);
    if (b <= AsciiMax) return 1;
    if (b >= Lead2Lo && b <= Lead2Hi) return 2;
    if (b >= Lead3Lo && b <= Lead3Hi) return 3;
    if (b >= Lead4Lo && b <= Lead4Hi) return 4;
    return 0;
  endfunction

  // all len bytes from pos on are present in win
  function automatic logic char_ok(input logic [3:0][7:0] win, input int pos, input int len);
    logic [7:0] lead;
    logic [7:0] second;
    lead   = win[pos];
    second = (pos < 3) ? win[pos+1] : 8'h00;
    for (int i = 1; i < len; i++) begin
      if ((win[pos+i] & ContMask) != ContTag) return 1'b0;
    end
    // overlong and surrogate / out-of-range bounds on the second byte
    if (len == 3 && lead == LeadE0 && second < E0SecMin) return 1'b0;
    if (len == 3 && lead == LeadED && second > EDSecMax) return 1'b0;
    if (len == 4 && lead == LeadF0 && second < F0SecMin) return 1'b0;
    if (len == 4 && lead == LeadF4 && second > F4SecMax) return 1'b0;
    return 1'b1;
  endfunction

  // works out what one accepted item releases and queues it
  task automatic predict_release(input cmd_e c, input logic [7:0] b);
    logic [3:0][7:0] win;
    rel_byte_t       rb;
    int              n;
    int              pos;
    int              len;
    int              rest;
    if (c == CMD_FLUSH) begin
      for (int k = 0; k < held_cnt; k++) begin
        rb.data = held_bytes[k];
        rb.last = (k == held_cnt - 1);
        rel_bytes_q = {rel_bytes_q, rb};
      end
      held_bytes = '0;
      held_cnt   = 0;
      return;
    end
    win = '0;
    for (int k = 0; k < held_cnt; k++) win[k] = held_bytes[k];
    win[held_cnt] = b;
    n   = held_cnt + 1;
    pos = 0;
    while (pos < n) begin
      len = char_len(win[pos]);
      if (len == 0) begin
        pos++;        // stray or invalid lead goes out alone
      end else if (pos + len > n) begin
        break;        // incomplete tail stays held
      end else if (!char_ok(win, pos, len)) begin
        pos++;
      end else begin
        pos += len;
      end
    end
    for (int k = 0; k < pos; k++) begin
      rb.data = win[k];
      rb.last = (k == pos - 1);
      rel_bytes_q = {rel_bytes_q, rb};
    end
    rest = n - pos;
    if (rest > HoldMax) rest = HoldMax;
    held_bytes = '0;
    for (int k = 0; k < rest; k++) held_bytes[k] = win[pos+k];
    held_cnt = rest;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Holds one item on the input until taken. Called right after a rising edge,
  // so each step sees at most one write to the valid.
  task automatic send_item(input cmd_e c, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= c;
    do @(posedge clk); while (!s_tready);
    predict_release(c, b);
    items_sent++;
    if (c == CMD_FLUSH) flushes_sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(CMD_DATA, b);
  endtask

  // data bits are don't-care on a flush; keep them moving anyway
  task automatic send_flush();
    logic [7:0] junk;
    junk = 8'($urandom);
    send_item(CMD_FLUSH, junk);
  endtask

  function automatic logic [7:0] rand_cont();
    logic [7:0] v;
    v = 8'($urandom);
    return {2'b10, v[5:0]};
  endfunction

  function automatic logic [7:0] rand_lead(input int len);
    logic [7:0] v;
    case (len)
      2:       v = 8'($urandom_range(Lead2Hi, Lead2Lo));
      3:       v = 8'($urandom_range(Lead3Hi, Lead3Lo));
      default: v = 8'($urandom_range(Lead4Hi, Lead4Lo));
    endcase
    return v;
  endfunction

  // valid second byte for a lead, honoring the E0/ED/F0/F4 bounds
  function automatic logic [7:0] rand_second(input logic [7:0] lead);
    logic [7:0] v;
    if (lead == LeadE0)      v = 8'($urandom_range(8'hBF, E0SecMin));
    else if (lead == LeadED) v = 8'($urandom_range(EDSecMax, 8'h80));
    else if (lead == LeadF0) v = 8'($urandom_range(8'hBF, F0SecMin));
    else if (lead == LeadF4) v = 8'($urandom_range(F4SecMax, 8'h80));
    else                     v = rand_cont();
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // ASCII extremes, stray continuation, bytes that never lead, empty flush
  task automatic test_single_bytes();
    send_data(8'h00);
    send_data(8'h7F);
    send_data(8'h80);
    send_data(8'hFF);
    send_data(8'hC1);
    send_flush();
  endtask

  // top of the 2-byte range, then a 2-byte lead cut short by ASCII
  task automatic test_two_byte();
    send_data(8'hDF);
    send_data(8'hBF);
    send_data(8'hC2);
    send_data(8'h41);
  endtask

  // E0 overlong releases three singles in one burst; ED at its upper bound
  task automatic test_three_byte_bounds();
    send_data(8'hE0);
    send_data(8'h9F);
    send_data(8'h80);
    send_data(8'hED);
    send_data(8'h9F);
    send_data(8'hBF);
  endtask

  // held tail with non-continuation bytes, judged once four are in (4 results);
  // then F4 at its upper bound
  task automatic test_four_byte_bounds();
    send_data(8'hF0);
    send_data(8'hC2);
    send_data(8'h80);
    send_data(8'h41);
    send_data(8'hF4);
    send_data(8'h8F);
    send_data(8'hBF);
    send_data(8'hBF);
  endtask

  // three bytes held, all of them out on a flush
  task automatic test_flush_pending();
    send_data(8'hF0);
    send_data(8'h90);
    send_data(8'h80);
    send_flush();
  endtask

  // Mostly well-formed text with random content, plus cut-off sequences,
  // out-of-bound second bytes, raw bytes and flushes.
  task automatic test_random_text(input int n_items);
    int         first;
    int         kind;
    int         len;
    int         keep;
    logic [7:0] lead;
    logic [7:0] b;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        b = 8'($urandom_range(AsciiMax, 0));
        send_data(b);
      end else if (kind < 77) begin
        // complete character of 2..4 bytes
        len  = (kind < 45) ? 2 : (kind < 62) ? 3 : 4;
        lead = rand_lead(len);
        send_data(lead);
        send_data(rand_second(lead));
        for (int k = 2; k < len; k++) send_data(rand_cont());
      end else if (kind < 85) begin
        // cut-off sequence, left for the next bytes or a flush to settle
        len  = $urandom_range(4, 2);
        keep = $urandom_range(len - 2, 0);
        lead = rand_lead(len);
        send_data(lead);
        if (keep > 0) send_data(rand_second(lead));
        for (int k = 1; k < keep; k++) send_data(rand_cont());
        if ($urandom_range(1)) send_flush();
      end else if (kind < 92) begin
        // second byte just outside the bound for its lead
        case ($urandom_range(3))
          0: begin
            lead = LeadE0; b = 8'($urandom_range(E0SecMin - 1, 8'h80)); len = 3;
          end
          1: begin
            lead = LeadED; b = 8'($urandom_range(8'hBF, EDSecMax + 1)); len = 3;
          end
          2: begin
            lead = LeadF0; b = 8'($urandom_range(F0SecMin - 1, 8'h80)); len = 4;
          end
          default: begin
            lead = LeadF4; b = 8'($urandom_range(8'hBF, F4SecMax + 1)); len = 4;
          end
        endcase
        send_data(lead);
        send_data(b);
        for (int k = 2; k < len; k++) send_data(rand_cont());
      end else if (kind < 96) begin
        b = 8'($urandom);
        send_data(b);
      end else begin
        send_flush();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stalls and result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (rel_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        rel_head = rel_bytes_q.pop_front();
        bytes_checked++;
        if (m_tdata !== rel_head.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, rel_head.data, m_tdata);
          errors++;
        end
        if (m_tlast !== rel_head.last) begin
          $display("%0t: chunk_end expected %0b actual %0b", $time, rel_head.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender light, receiver heavy
    send_idle_pct = 18;
    recv_idle_pct = 47;
    test_single_bytes();
    test_two_byte();
    test_three_byte_bounds();
    test_four_byte_bounds();
    test_flush_pending();
    test_random_text(134);

    // sender heavy, receiver light
    send_idle_pct = 47;
    recv_idle_pct = 18;
    test_random_text(133);

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(133);
    s_tvalid <= 1'b0;

    drain = 0;
    while (rel_bytes_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (rel_bytes_q.size() != 0) begin
      $display("%0t: %0d released bytes never arrived", $time, rel_bytes_q.size());
      errors++;
    end

    $display("covered %0d input items (%0d flushes) under three stall profiles",
             items_sent, flushes_sent);
    $display("checked %0d released bytes, %0d mismatches", bytes_checked, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run guard, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
